// File: hw/rtl/quaternion_w_rebuild_continuity_core_macros.svh
// Assertion macros used by the rebuild continuity core controller.
// Bodies expect signals named clk and rst_n in the enclosing module.
`ifndef QUATERNION_W_REBUILD_CONTINUITY_CORE_MACROS_SVH
`define QUATERNION_W_REBUILD_CONTINUITY_CORE_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define QWRC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qwrc assertion failed");
// antecedent implies consequent in the next cycle
`define QWRC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("qwrc assertion failed");
`else
`define QWRC_ASSERT_IMPL(label, ante, cons)
`define QWRC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: hw/rtl/qwrc_pkg.sv
// Types and constants of the quaternion w rebuild continuity core.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package qwrc_pkg;

  // Squared unit length minus one rounding margin, 32767^2
  localparam logic [31:0] UNIT_REMAINDER = 32'd1073676289;
  // Root iterations, one result bit each
  localparam int unsigned SQRT_STEPS = 16;
  localparam int unsigned CNT_W = $clog2(SQRT_STEPS);
  localparam int unsigned DOT_LANES = 4;

  typedef struct packed {
    logic               first_frame;
    logic               two_lane;
    logic               negate_first;
    logic signed [15:0] lane_x;
    logic signed [15:0] lane_y;
    logic signed [15:0] lane_z;
  } in_t;

  typedef struct packed {
    logic signed [15:0] out_lane0;
    logic signed [15:0] out_lane1;
    logic signed [15:0] out_lane2;
    logic signed [15:0] out_lane3;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic             load;
    logic             acc_clr;
    logic             acc_add;
    logic             mul_en;
    logic             mul_dot;
    logic             sqrt_init;
    logic             sqrt_step;
    logic             round;
    logic             finish;
    logic [CNT_W-1:0] cnt;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic two_lane;
  } ctrl_sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/qwrc_ctrl.sv
// Sequencer of the rebuild core: squares, root iterations, dot product, writeback.
// Depends on qwrc_pkg and the core macro header.
`default_nettype none
`include "quaternion_w_rebuild_continuity_core_macros.svh"

module qwrc_ctrl
  import qwrc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire ctrl_sts_t sts,
  output ctrl_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SQ     = 3'd1;
  localparam logic [2:0] S_RINIT  = 3'd2;
  localparam logic [2:0] S_ROOT   = 3'd3;
  localparam logic [2:0] S_ROUND  = 3'd4;
  localparam logic [2:0] S_DOT    = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SQRT_STEPS - 1);
  localparam logic [CNT_W-1:0] CNT_DOT  = CNT_W'(DOT_LANES);

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0] n_sq;
  logic             out_free;

  // number of carried lanes to square
  assign n_sq     = sts.two_lane ? CNT_W'(1) : CNT_W'(3);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.cnt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load    = 1'b1;
          cmd.acc_clr = 1'b1;
          cnt_nxt     = '0;
          state_nxt   = S_SQ;
        end
      end
      S_SQ: begin
        cmd.mul_en  = (cnt_r < n_sq);
        cmd.acc_add = (cnt_r != '0);
        if (cnt_r == n_sq) begin
          cnt_nxt   = '0;
          state_nxt = S_RINIT;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_RINIT: begin
        cmd.sqrt_init = 1'b1;
        cmd.acc_clr   = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_ROOT;
      end
      S_ROOT: begin
        cmd.sqrt_step = 1'b1;
        if (cnt_r == CNT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_ROUND;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_ROUND: begin
        cmd.round = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DOT;
      end
      S_DOT: begin
        cmd.mul_dot = 1'b1;
        cmd.mul_en  = (cnt_r < CNT_DOT);
        cmd.acc_add = (cnt_r != '0);
        if (cnt_r == CNT_DOT) begin
          cnt_nxt   = '0;
          state_nxt = S_FINISH;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output valid: set on writeback, cleared when taken
  always_comb begin
    priority if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `QWRC_ASSERT_IMPL(a_no_overwrite, cmd.finish, !(out_valid_r && out_stall))
  `QWRC_ASSERT_NEXT(a_load_starts_sq, in_valid && !in_stall, state_r == S_SQ && cnt_r == '0)
  `QWRC_ASSERT_NEXT(a_root_len, state_r == S_ROOT && cnt_r == CNT_LAST, state_r == S_ROUND)
  `QWRC_ASSERT_IMPL(a_valid_from_finish, $rose(out_valid_r), $past(cmd.finish))

endmodule

`default_nettype wire

// File: hw/rtl/qwrc_datapath.sv
// Datapath of the rebuild core: shared multiplier, accumulator, root unit, frame state.
// Depends on qwrc_pkg.
`default_nettype none

module qwrc_datapath
  import qwrc_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire in_t       in_data,
  input  wire ctrl_cmd_t cmd,
  output ctrl_sts_t      sts,
  output out_t           out_data
);

  in_t                in_r;
  logic signed [31:0] prod_r;
  logic signed [33:0] acc_r;
  logic [31:0]        v_r;
  logic [31:0]        res_r;
  logic [15:0]        root_r;
  logic [15:0]        prev_r [DOT_LANES];
  out_t               out_r;

  logic [15:0]        lane_sq [4];
  logic [15:0]        frame   [DOT_LANES];
  logic signed [15:0] mul_a, mul_b;
  logic [31:0]        rem;
  logic               rem_ok;
  logic [4:0]         shamt;
  logic [31:0]        bit_w, trial;
  logic               neg;

  assign sts.two_lane = in_r.two_lane;
  assign out_data     = out_r;

  // carried lanes for squaring; unused slot reads zero
  assign lane_sq[0] = in_r.lane_x;
  assign lane_sq[1] = in_r.lane_y;
  assign lane_sq[2] = in_r.lane_z;
  assign lane_sq[3] = '0;

  // uncorrected frame with the rebuilt lane in place
  assign frame[0] = in_r.lane_x;
  assign frame[1] = in_r.two_lane ? root_r : in_r.lane_y;
  assign frame[2] = in_r.two_lane ? 16'd0 : in_r.lane_z;
  assign frame[3] = in_r.two_lane ? 16'd0 : root_r;

  // shared multiplier operand select
  always_comb begin
    if (cmd.mul_dot) begin
      mul_a = prev_r[cmd.cnt[1:0]];
      mul_b = frame[cmd.cnt[1:0]];
    end else begin
      mul_a = lane_sq[cmd.cnt[1:0]];
      mul_b = lane_sq[cmd.cnt[1:0]];
    end
  end

  // remainder under the root; not positive gives root zero
  assign rem    = UNIT_REMAINDER - acc_r[31:0];
  assign rem_ok = (rem != 32'd0) && !rem[31];

  // root iteration: bit weight 4^(15-cnt)
  assign shamt = 5'd30 - {cmd.cnt, 1'b0};
  assign bit_w = 32'd1 << shamt;
  assign trial = res_r + bit_w;

  // continuity decision
  assign neg = in_r.first_frame ? in_r.negate_first : acc_r[33];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_data;
    end
    if (cmd.mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    priority if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.acc_add) begin
      acc_r <= acc_r + 34'(prod_r);
    end
    priority if (cmd.sqrt_init) begin
      v_r   <= rem_ok ? rem : 32'd0;
      res_r <= '0;
    end else if (cmd.sqrt_step) begin
      if (v_r >= trial) begin
        v_r   <= v_r - trial;
        res_r <= (res_r >> 1) + bit_w;
      end else begin
        res_r <= res_r >> 1;
      end
    end
    // round to nearest: remainder above root means bump
    if (cmd.round) begin
      root_r <= res_r[15:0] + {15'd0, (v_r > res_r)};
    end
    if (cmd.finish) begin
      out_r.out_lane0 <= neg ? -frame[0] : frame[0];
      out_r.out_lane1 <= neg ? -frame[1] : frame[1];
      out_r.out_lane2 <= neg ? -frame[2] : frame[2];
      out_r.out_lane3 <= neg ? -frame[3] : frame[3];
    end
  end

  // previous corrected frame, zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DOT_LANES; i++) begin
        prev_r[i] <= '0;
      end
    end else if (cmd.finish) begin
      for (int i = 0; i < DOT_LANES; i++) begin
        prev_r[i] <= neg ? -frame[i] : frame[i];
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/quaternion_w_rebuild_continuity_core.sv
// Top level of the quaternion w rebuild core with sign continuity.
// Depends on qwrc_pkg, qwrc_ctrl and qwrc_datapath.
//
//   channel  direction  payload  handshake
//   in_      input      in_t     in_valid / in_stall
//   out_     output     out_t    out_valid / out_stall
//
// From acceptance to the result register, in four-lane and two-lane mode,
// the 16-step root iteration dominates the time of a frame, plus one shared
// 16x16 multiplier for the squares and the 4-lane dot product.
// The next frame is taken in the cycle after writeback. rst_n is synchronous;
// it clears the sequencer, output valid and the stored previous frame. A new
// frame is taken while a result waits; writeback holds while out_stall keeps
// the earlier result in the output register.
`default_nettype none

module quaternion_w_rebuild_continuity_core
  import qwrc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  qwrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  qwrc_datapath u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for quaternion_w_rebuild_continuity_core.
// Depends on qwrc_pkg for the in_t and out_t payloads; predicts every frame
// and checks each result transaction against the oldest pending prediction.

module tb_top
  import qwrc_pkg::*;
;

  localparam logic [31:0] UNIT_SQ      = 32'd1073676289;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam int          TAIL_CYCLES  = 64;
  localparam int          STREAM_ITEMS = 500;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  // Predictor state: last corrected frame, and frames still owed by the block
  logic signed [15:0] last_frame [4] = '{16'sd0, 16'sd0, 16'sd0, 16'sd0};
  out_t pending_frames [$];
  out_t want;

  int mismatches  = 0;
  int cycle_count = 0;
  int send_idle_pct;
  int recv_idle_pct;

  quaternion_w_rebuild_continuity_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Square of a signed lane, kept modulo 2^32
  function automatic logic [31:0] lane_square(logic signed [15:0] v);
    int s;
    s = v;
    return 32'(s * s);
  endfunction

  // Rounded root of the unit remainder; zero when the remainder is not positive
  function automatic logic [15:0] rounded_root(logic [31:0] sumsq);
    logic [31:0] r;
    longint      rem;
    int          root;
    int          trial;
    int          b;
    r = UNIT_SQ - sumsq;
    if (r == 32'd0 || r[31]) return 16'd0;
    rem  = r;
    root = 0;
    for (b = 15; b >= 0; b--) begin
      trial = root | (1 << b);
      if (longint'(trial) * trial <= rem) root = trial;
    end
    if (rem > longint'(root) * root + root) root++;
    return root[15:0];
  endfunction

  // Expected corrected frame; advances the stored previous frame
  function automatic out_t predict_frame(in_t t);
    logic signed [15:0] lane [4];
    logic [31:0]        sumsq;
    longint             dot;
    bit                 flip;
    int                 i;
    out_t               o;
    lane[0] = t.lane_x;
    sumsq   = lane_square(t.lane_x);
    if (t.two_lane) begin
      lane[1] = rounded_root(sumsq);
      lane[2] = 16'sd0;
      lane[3] = 16'sd0;
    end else begin
      sumsq   = sumsq + lane_square(t.lane_y) + lane_square(t.lane_z);
      lane[1] = t.lane_y;
      lane[2] = t.lane_z;
      lane[3] = rounded_root(sumsq);
    end
    if (t.first_frame) begin
      flip = t.negate_first;
    end else begin
      dot = 0;
      for (i = 0; i < 4; i++) dot += longint'(last_frame[i]) * longint'(lane[i]);
      flip = (dot < 0);
    end
    // negation wraps in 16 bits; zero lanes stay zero
    if (flip) begin
      for (i = 0; i < 4; i++) lane[i] = -lane[i];
    end
    for (i = 0; i < 4; i++) last_frame[i] = lane[i];
    o.out_lane0 = lane[0];
    o.out_lane1 = lane[1];
    o.out_lane2 = lane[2];
    o.out_lane3 = lane[3];
    return o;
  endfunction

  // Record a prediction for every accepted input transaction
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) pending_frames.push_back(predict_frame(in_data));
  end

  task automatic compare_lane(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Check each result transaction against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_frames.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %h", $time, out_data);
        mismatches++;
      end else begin
        want = pending_frames.pop_front();
        compare_lane("out_lane0", want.out_lane0, out_data.out_lane0);
        compare_lane("out_lane1", want.out_lane1, out_data.out_lane1);
        compare_lane("out_lane2", want.out_lane2, out_data.out_lane2);
        compare_lane("out_lane3", want.out_lane3, out_data.out_lane3);
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // Hard stop on a hung block
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("quaternion_w_rebuild_continuity_core: mismatch");
    $finish;
  end

  // Present one frame, with random idle cycles ahead of it, until accepted.
  // Returns at the accepting edge with in_valid still high.
  task automatic send_frame(in_t frame);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= frame;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_lanes(bit first, bit two, bit negf,
                            logic signed [15:0] x, logic signed [15:0] y,
                            logic signed [15:0] z);
    in_t f;
    f.first_frame  = first;
    f.two_lane     = two;
    f.negate_first = negf;
    f.lane_x       = x;
    f.lane_y       = y;
    f.lane_z       = z;
    send_frame(f);
  endtask

  // Hold off the sender until every pending result has come out
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_frames.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [15:0] pick_lane();
    case ($urandom_range(0, 5))
      0, 1: return 16'($urandom);
      2, 3: return 16'($urandom_range(0, 36000)) - 16'sd18000;
      4: begin
        case ($urandom_range(0, 4))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return 16'sh0000;
          3: return 16'shFFFF;
          default: return 16'sh0001;
        endcase
      end
      default: return 16'($urandom_range(0, 128)) - 16'sd64;
    endcase
  endfunction

  // Corner frames; the first one runs before any first frame was seen
  task automatic test_directed_cases();
    // previous frame is still zero: no negation
    send_lanes(0, 0, 1, 16'sd1000, 16'sd2000, 16'sd3000);
    // root overflow, then negation of -32768 lanes
    send_lanes(1, 0, 1, 16'sh8000, 16'sh8000, 16'sh8000);
    send_lanes(1, 0, 0, 16'sh8000, 16'sh8000, 16'sh8000);
    // remainder exactly zero, then negative
    send_lanes(1, 0, 0, 16'sh7FFF, 16'sd0, 16'sd0);
    send_lanes(0, 0, 0, 16'sh7FFF, 16'sh7FFF, 16'sd0);
    send_lanes(0, 0, 0, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
    send_lanes(0, 0, 0, 16'sh8000, 16'sh8000, 16'sd0);
    // identity, then near identity
    send_lanes(1, 0, 0, 16'sd0, 16'sd0, 16'sd0);
    send_lanes(0, 0, 1, -16'sd1, -16'sd1, -16'sd1);
    // continuity flip
    send_lanes(1, 0, 0, 16'sd20000, 16'sd20000, 16'sd0);
    send_lanes(0, 0, 0, -16'sd20000, -16'sd20000, 16'sd0);
    send_lanes(0, 0, 0, -16'sd20000, -16'sd19000, 16'sd100);
    // two-lane mode with junk in the unused lanes
    send_lanes(1, 1, 1, 16'sd12345, 16'sh8000, 16'sh7FFF);
    send_lanes(0, 1, 0, -16'sd12345, 16'sh7FFF, 16'sh8000);
    send_lanes(0, 1, 0, -16'sd12000, 16'shFFFF, 16'sh5555);
    // mode changes inside a stream
    send_lanes(0, 0, 0, 16'sd12000, 16'sd3000, -16'sd4000);
    send_lanes(0, 1, 1, 16'sd11000, 16'shAAAA, 16'sh0001);
    // two-lane extremes
    send_lanes(1, 1, 0, 16'sh8000, 16'sd0, 16'sd0);
    send_lanes(1, 1, 1, 16'sh8000, 16'sd0, 16'sd0);
    send_lanes(0, 1, 0, 16'sh7FFF, 16'sd0, 16'sd0);
    send_lanes(0, 1, 1, 16'sd0, 16'sd0, 16'sd0);
    send_lanes(0, 1, 0, 16'shFFFF, 16'sh7FFF, 16'sh7FFF);
    // four-lane extremes with negate_first on a later frame
    send_lanes(0, 0, 1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_lanes(1, 0, 1, 16'shFFFF, 16'sh0001, 16'sh8000);
  endtask

  // Streams of slowly turning frames with random flips, plus junk frames
  task automatic test_streams(int n_frames);
    int                 sent;
    int                 len;
    int                 k;
    bit                 two;
    logic signed [15:0] x, y, z;
    logic [63:0]        raw;
    in_t                f;
    sent = 0;
    while (sent < n_frames) begin
      two = ($urandom_range(0, 3) == 0);
      len = $urandom_range(1, 12);
      x   = pick_lane();
      y   = pick_lane();
      z   = pick_lane();
      for (k = 0; k < len; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          raw = {$urandom, $urandom};
          f   = raw[$bits(in_t)-1:0];
        end else begin
          if (k > 0) begin
            x = x + 16'($urandom_range(0, 2047)) - 16'sd1024;
            y = y + 16'($urandom_range(0, 2047)) - 16'sd1024;
            z = z + 16'($urandom_range(0, 2047)) - 16'sd1024;
            if ($urandom_range(0, 3) == 0) begin
              x = -x;
              y = -y;
              z = -z;
            end
            if ($urandom_range(0, 19) == 0) two = ~two;
          end
          // now and then a stream starts without its first frame
          f.first_frame  = (k == 0) && ($urandom_range(0, 15) != 0);
          f.two_lane     = two;
          f.negate_first = 1'($urandom_range(0, 1));
          f.lane_x       = x;
          f.lane_y       = two ? 16'($urandom) : y;
          f.lane_z       = two ? 16'($urandom) : z;
        end
        send_frame(f);
        sent++;
        if ($urandom_range(0, 299) == 0) wait_results_drained();
      end
    end
  endtask

  // Sender pauses until the block has emptied, then resumes
  task automatic test_pressure_pause();
    int k;
    for (k = 0; k < 6; k++) begin
      send_lanes(k == 0, 0, 1'($urandom_range(0, 1)), pick_lane(), pick_lane(), pick_lane());
    end
    wait_results_drained();
    send_lanes(0, 1, 0, pick_lane(), 16'($urandom), 16'($urandom));
    send_lanes(0, 0, 0, pick_lane(), pick_lane(), pick_lane());
  endtask

  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_data       <= '0;
    send_idle_pct  = 19;
    recv_idle_pct  = 55;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_pressure_pause();
    test_streams(STREAM_ITEMS);

    send_idle_pct = 55;
    recv_idle_pct = 19;
    test_streams(STREAM_ITEMS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_streams(STREAM_ITEMS);

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_frames.size() == 0) begin
      $display("quaternion_w_rebuild_continuity_core: match");
    end else begin
      $display("quaternion_w_rebuild_continuity_core: mismatch");
    end
    $finish;
  end

endmodule
